/* rtl/scp_pkg.sv */
// Shared types, codes and constants for the system controller packet responder.
package scp_pkg;

  localparam int PRAM_DEPTH_DEF = 256;
  localparam int QUEUE_DEPTH    = 2;
  localparam int REPLY_MAX      = 7;

  localparam logic [31:0] CLOCK_BASE = 32'd3029529600;

  // Packet types
  localparam logic [7:0] TYPE_BUS    = 8'h00;
  localparam logic [7:0] TYPE_PSEUDO = 8'h01;

  // Pseudo command codes
  localparam logic [7:0] CMD_GET_TIME = 8'h03;
  localparam logic [7:0] CMD_SET_TIME = 8'h09;
  localparam logic [7:0] CMD_GET_PRAM = 8'h07;
  localparam logic [7:0] CMD_SET_PRAM = 8'h0C;
  localparam logic [7:0] CMD_AUTOPOLL = 8'h01;
  localparam logic [7:0] CMD_ABSENT   = 8'hFF;

  // Reply header bytes
  localparam logic [7:0] HDR_BUS    = 8'h00;
  localparam logic [7:0] HDR_PSEUDO = 8'h01;
  localparam logic [7:0] HDR_ERROR  = 8'h02;
  localparam logic [7:0] ERR_BAD_TYPE = 8'h02;
  localparam logic [7:0] FLAG_OK      = 8'h00;
  localparam logic [7:0] FLAG_TIMEOUT = 8'h01;

  // Input bus stub devices
  localparam logic [1:0] BUS_OP_TALK  = 2'd3;
  localparam logic [1:0] BUS_REG_INFO = 2'd3;
  localparam logic [3:0] DEV_ADDR_A   = 4'd2;
  localparam logic [3:0] DEV_ADDR_B   = 4'd3;
  localparam logic [7:0] DEV_INFO_HI  = 8'h60;
  localparam logic [7:0] HANDLER_A    = 8'h02;
  localparam logic [7:0] HANDLER_B    = 8'h01;

  // One queued reply: its bytes in order and how many are sent.
  typedef struct packed {
    logic [2:0]           count;
    logic [6:0][7:0]      bytes;
  } reply_desc_t;

  typedef struct packed {
    logic stage_busy;
    logic autopoll_on;
  } front_status_t;

endpackage

/* rtl/system_controller_packet_responder.sv */
// Top level of the system controller packet responder.
//
//   channel | role | handshake                   | fields
//   packet  | in   | packet_valid / packet_stall | packet_length packet_type command data0..3
//   reply   | out  | reply_valid / reply_stall   | reply_byte last
//
// A packet is accepted when not stalled; the front registers its reply
// descriptor and hands it to a two-entry queue. The back sends 3 to 7 reply
// bytes, one per cycle while reply_stall is low, so sustained throughput is
// set by the single byte lane of the back end. Empty packets send nothing.
// Reset clears the clock offset, autopoll and PRAM valid bits at once; PRAM
// entries never written read as zero. The packet side stalls only when the
// front stage holds an item and the queue is full; a stalled reply holds its
// byte.
module system_controller_packet_responder #(
  parameter int PRAM_DEPTH = scp_pkg::PRAM_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       packet_valid,
  output logic       packet_stall,
  input  logic [2:0] packet_length,
  input  logic [7:0] packet_type,
  input  logic [7:0] command,
  input  logic [7:0] data0,
  input  logic [7:0] data1,
  input  logic [7:0] data2,
  input  logic [7:0] data3,
  output logic       reply_valid,
  input  logic       reply_stall,
  output logic [7:0] reply_byte,
  output logic       last
);

  logic                   push;
  scp_pkg::reply_desc_t   push_desc;
  logic                   pop;
  scp_pkg::reply_desc_t   head;
  logic                   q_empty;
  logic                   q_full;
  scp_pkg::front_status_t fr_status;

  // Front: classify the packet, apply state changes, build the reply.
  scp_front #(
    .PRAM_DEPTH(PRAM_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .packet_valid (packet_valid),
    .packet_stall (packet_stall),
    .packet_length(packet_length),
    .packet_type  (packet_type),
    .command      (command),
    .data0        (data0),
    .data1        (data1),
    .data2        (data2),
    .data3        (data3),
    .push         (push),
    .push_desc    (push_desc),
    .queue_full   (q_full),
    .status       (fr_status)
  );

  // Queue: decouple descriptor building from byte sending.
  scp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_desc(push_desc),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back: send the head reply byte by byte.
  scp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .reply_valid(reply_valid),
    .reply_stall(reply_stall),
    .reply_byte (reply_byte),
    .last       (last)
  );

  // Never push a descriptor into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("reply queue overflow");

  // A stall on the packet side only happens while the front stage is busy.
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    packet_stall |-> fr_status.stage_busy)
    else $error("packet stalled with idle front stage");

  // A reply that has sent a non-final byte keeps going.
  a_reply_continues: assert property (@(posedge clk) disable iff (rst)
    (reply_valid && !reply_stall && !last) |=> reply_valid)
    else $error("reply cut short");

  // Autopoll changes only after an accepted packet.
  a_autopoll_stable: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(packet_valid && !packet_stall)) |->
      $stable(fr_status.autopoll_on))
    else $error("autopoll changed without a packet");

endmodule

/* rtl/scp_front.sv */
// Front end: accepts packets, updates clock, PRAM and autopoll, builds reply descriptors.
module scp_front #(
  parameter int PRAM_DEPTH = scp_pkg::PRAM_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                packet_valid,
  output logic                packet_stall,
  input  logic [2:0]          packet_length,
  input  logic [7:0]          packet_type,
  input  logic [7:0]          command,
  input  logic [7:0]          data0,
  input  logic [7:0]          data1,
  input  logic [7:0]          data2,
  input  logic [7:0]          data3,
  output logic                push,
  output scp_pkg::reply_desc_t push_desc,
  input  logic                queue_full,
  output scp_pkg::front_status_t status
);

  localparam int AW = (PRAM_DEPTH > 1) ? $clog2(PRAM_DEPTH) : 1;

  logic [AW-1:0]          idx_tab [256];
  logic [7:0]             pram [PRAM_DEPTH];
  logic [PRAM_DEPTH-1:0]  pram_vld;
  logic [7:0]             rd_data;
  logic                   rd_vld;

  logic [31:0]            clock_offset;
  logic                   autopoll_on;

  logic                   stage_valid;
  scp_pkg::reply_desc_t   stage_desc;
  logic                   stage_pram_sel;

  logic                   accept;
  logic                   load;
  logic [2:0]             len;
  logic                   has_cmd, has_d0, has_d1, has_all;
  logic [7:0]             cmd_bus, cmd_ps;
  logic [3:0]             bus_addr;
  logic                   bus_present;
  logic [31:0]            time_now;
  logic [AW-1:0]          pram_addr;
  logic                   pram_we;
  logic                   time_we;
  logic                   set_autopoll;
  scp_pkg::reply_desc_t   desc_next;
  logic                   pram_sel_next;

  // Address reduction table, worked out at elaboration.
  for (genvar i = 0; i < 256; i++) begin : g_idx
    assign idx_tab[i] = AW'(i % PRAM_DEPTH);
  end

  assign packet_stall = stage_valid && queue_full;
  assign accept       = packet_valid && !packet_stall;
  assign len          = (packet_length == 3'd7) ? 3'd6 : packet_length;
  assign load         = accept && (len != 3'd0);
  assign push         = stage_valid && !queue_full;

  always_comb begin
    has_cmd     = len > 3'd1;
    has_d0      = len > 3'd2;
    has_d1      = len > 3'd3;
    has_all     = len == 3'd6;
    cmd_bus     = has_cmd ? command : 8'h00;
    cmd_ps      = has_cmd ? command : scp_pkg::CMD_ABSENT;
    bus_addr    = cmd_bus[7:4];
    bus_present = (bus_addr == scp_pkg::DEV_ADDR_A) || (bus_addr == scp_pkg::DEV_ADDR_B);
    time_now    = scp_pkg::CLOCK_BASE + clock_offset;
    pram_addr   = idx_tab[has_d0 ? data0 : 8'h00];

    desc_next      = '0;
    desc_next.count = 3'd3;
    pram_sel_next  = 1'b0;
    pram_we        = 1'b0;
    time_we        = 1'b0;
    set_autopoll   = 1'b0;

    unique case (packet_type)
      scp_pkg::TYPE_BUS: begin
        desc_next.bytes[0] = scp_pkg::HDR_BUS;
        desc_next.bytes[1] = scp_pkg::FLAG_OK;
        desc_next.bytes[2] = cmd_bus;
        if (cmd_bus[3:2] == scp_pkg::BUS_OP_TALK) begin
          if (bus_present && cmd_bus[1:0] == scp_pkg::BUS_REG_INFO) begin
            desc_next.bytes[3] = scp_pkg::DEV_INFO_HI | {4'h0, bus_addr};
            desc_next.bytes[4] = (bus_addr == scp_pkg::DEV_ADDR_A) ?
                                 scp_pkg::HANDLER_A : scp_pkg::HANDLER_B;
            desc_next.count    = 3'd5;
          end else begin
            desc_next.bytes[1] = scp_pkg::FLAG_TIMEOUT;
          end
        end
      end
      scp_pkg::TYPE_PSEUDO: begin
        desc_next.bytes[0] = scp_pkg::HDR_PSEUDO;
        desc_next.bytes[1] = scp_pkg::FLAG_OK;
        desc_next.bytes[2] = cmd_ps;
        unique case (cmd_ps)
          scp_pkg::CMD_GET_TIME: begin
            desc_next.bytes[3] = time_now[31:24];
            desc_next.bytes[4] = time_now[23:16];
            desc_next.bytes[5] = time_now[15:8];
            desc_next.bytes[6] = time_now[7:0];
            desc_next.count    = 3'd7;
          end
          scp_pkg::CMD_SET_TIME: time_we = has_all;
          scp_pkg::CMD_GET_PRAM: begin
            pram_sel_next   = 1'b1;
            desc_next.count = 3'd4;
          end
          scp_pkg::CMD_SET_PRAM: pram_we = has_d1;
          scp_pkg::CMD_AUTOPOLL: set_autopoll = 1'b1;
          default: ;
        endcase
      end
      default: begin
        desc_next.bytes[0] = scp_pkg::HDR_ERROR;
        desc_next.bytes[1] = scp_pkg::ERR_BAD_TYPE;
        desc_next.bytes[2] = packet_type;
      end
    endcase
  end

  // Parameter RAM: read registered on every accept, write on set-PRAM with a data byte.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= pram[pram_addr];
    end
    if (load && pram_we) begin
      pram[pram_addr] <= data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pram_vld     <= '0;
      rd_vld       <= 1'b0;
      clock_offset <= '0;
      autopoll_on  <= 1'b0;
      stage_valid  <= 1'b0;
    end else begin
      if (accept) begin
        rd_vld <= pram_vld[pram_addr];
      end
      if (load && pram_we) begin
        pram_vld[pram_addr] <= 1'b1;
      end
      if (load && time_we) begin
        clock_offset <= {data0, data1, data2, data3} - scp_pkg::CLOCK_BASE;
      end
      if (load && set_autopoll) begin
        autopoll_on <= has_d0 && (data0 != 8'h00);
      end
      if (load) begin
        stage_valid <= 1'b1;
      end else if (push) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_desc     <= desc_next;
      stage_pram_sel <= pram_sel_next;
    end
  end

  always_comb begin
    push_desc = stage_desc;
    if (stage_pram_sel) begin
      push_desc.bytes[3] = rd_vld ? rd_data : 8'h00;
    end
  end

  assign status = '{stage_busy: stage_valid, autopoll_on: autopoll_on};

endmodule

/* rtl/scp_queue.sv */
// Short queue of reply descriptors between front and back.
module scp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  scp_pkg::reply_desc_t push_desc,
  input  logic                 pop,
  output scp_pkg::reply_desc_t head,
  output logic                 empty,
  output logic                 full
);

  localparam int DEPTH = scp_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  scp_pkg::reply_desc_t entries [DEPTH];
  logic [PW-1:0]        wptr, rptr;
  logic [CW-1:0]        count;

  assign empty = count == '0;
  assign full  = count == CW'(DEPTH);
  assign head  = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/scp_back.sv */
// Back end: walks the head reply descriptor and sends one byte per cycle unless stalled.
module scp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  scp_pkg::reply_desc_t head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 reply_valid,
  input  logic                 reply_stall,
  output logic [7:0]           reply_byte,
  output logic                 last
);

  logic [2:0] idx;
  logic       send;

  assign reply_valid = !empty;
  assign reply_byte  = head.bytes[idx];
  assign last        = idx == (head.count - 3'd1);
  assign send        = reply_valid && !reply_stall;
  assign pop         = send && last;

  // Advance through the reply; rewind when its last byte goes out.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (send) begin
      idx <= last ? 3'd0 : idx + 3'd1;
    end
  end

endmodule
